FILE: hw/rtl/gradient_rect_alpha_fill_core_macros.svh
// Assertion macros shared by the checker of gradient_rect_alpha_fill_core.
// No dependencies; include by bare file name.
`ifndef GRADIENT_RECT_ALPHA_FILL_CORE_MACROS_SVH
`define GRADIENT_RECT_ALPHA_FILL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/grf_pkg.sv
// Types and constants of the gradient rectangle fill compositor.
// No dependencies; used by the front, back and top modules and the checker.
package grf_pkg;

    // color channels, in the byte order of the packed colors
    localparam int CH       = 3;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam int IW = 10;          // row offset inside the rectangle
    localparam int QW = 18;          // gradient numerator and quotient
    localparam int DW = 11;          // gradient divisor (height - 1)

    localparam int QDEPTH     = 4;   // front-to-back queue entries
    localparam int PIPE_SLOTS = QDEPTH + QW + 4;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;

    localparam logic [CFG_IW-1:0] REG_RECT_LEFT   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_RECT_TOP    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [CFG_IW-1:0] REG_COLOR_START = 3'd4;
    localparam logic [CFG_IW-1:0] REG_COLOR_END   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_BLEND_ALPHA = 3'd6;
    localparam logic [CFG_IW-1:0] REG_GRADIENT_ON = 3'd7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [11:0] rect_left;      // two's complement
        logic [11:0] rect_top;       // two's complement
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [23:0] color_start;
        logic [23:0] color_end;
        logic [7:0]  blend_alpha;
        logic        gradient_on;
    } cfg_t;

    // pixel payload carried down the back pipeline
    typedef struct packed {
        logic [CH-1:0][7:0] bg;
        logic [7:0]         bg_a;
        logic [CH-1:0][7:0] c1;
        logic               covered;
        logic               paint;   // covered and alpha nonzero
        logic               grad;    // gradient on and height above one
    } px_t;

    // classified item as queued between front and back
    typedef struct packed {
        px_t                px;
        logic [IW-1:0]      row_ofs;
        logic [CH-1:0]      diff_neg;
        logic [CH-1:0][7:0] diff_mag;
    } fe_t;

endpackage

FILE: hw/rtl/grf_fifo.sv
// Small register queue between the front and back of the compositor.
// No package dependency; width and depth come in as parameters.
module grf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rdata = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: hw/rtl/grf_front.sv
// Front end: takes pixel transactions, tests them against the clipped
// rectangle and prepares the gradient operands. Uses grf_pkg.
module grf_front #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600
) (
    input  grf_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [9:0]     pixel_col,
    input  logic [9:0]     pixel_row,
    input  logic [7:0]     bg_blue,
    input  logic [7:0]     bg_green,
    input  logic [7:0]     bg_red,
    input  logic [7:0]     bg_alpha,
    input  logic           q_full,
    output logic           q_push,
    output grf_pkg::fe_t   q_entry
);

    localparam logic [11:0] SW_L = 12'(SCREEN_WIDTH);
    localparam logic [11:0] SH_L = 12'(SCREEN_HEIGHT);

    logic signed [12:0] left_s, top_s, xend_s, yend_s, col_s, row_s;
    logic               in_x, in_y, cov;
    logic [8:0]         diff [grf_pkg::CH];

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign left_s = $signed({cfg.rect_left[11], cfg.rect_left});
    assign top_s  = $signed({cfg.rect_top[11], cfg.rect_top});
    assign xend_s = left_s + $signed({2'b00, cfg.rect_width});
    assign yend_s = top_s + $signed({2'b00, cfg.rect_height});
    assign col_s  = $signed({3'b000, pixel_col});
    assign row_s  = $signed({3'b000, pixel_row});

    // clipping at the screen origin is implied by the coordinates being unsigned
    assign in_x = (col_s >= left_s) && (col_s < xend_s) && ({2'b00, pixel_col} < SW_L);
    assign in_y = (row_s >= top_s) && (row_s < yend_s) && ({2'b00, pixel_row} < SH_L);
    assign cov  = in_x && in_y;

    always_comb
    begin
        q_entry.px.bg[grf_pkg::CH_BLUE]  = bg_blue;
        q_entry.px.bg[grf_pkg::CH_GREEN] = bg_green;
        q_entry.px.bg[grf_pkg::CH_RED]   = bg_red;
        q_entry.px.bg_a    = bg_alpha;
        q_entry.px.covered = cov;
        q_entry.px.paint   = cov && (cfg.blend_alpha != '0);
        q_entry.px.grad    = cfg.gradient_on && (cfg.rect_height > 11'd1);

        // offset from the clipped top row
        q_entry.row_ofs = cfg.rect_top[11] ? pixel_row : pixel_row - cfg.rect_top[9:0];

        for (int c = 0; c < grf_pkg::CH; c++)
        begin
            q_entry.px.c1[c]     = cfg.color_start[8*c +: 8];
            diff[c]              = {1'b0, cfg.color_end[8*c +: 8]}
                                 - {1'b0, cfg.color_start[8*c +: 8]};
            q_entry.diff_neg[c]  = diff[c][8];
            q_entry.diff_mag[c]  = diff[c][8] ? 8'(-diff[c]) : diff[c][7:0];
        end
    end

endmodule

FILE: hw/rtl/grf_back.sv
// Back end: gradient product, pipelined restoring divide, blend and the
// output register. Uses grf_pkg; pops items from the front queue.
module grf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  grf_pkg::cfg_t cfg,
    input  grf_pkg::fe_t  head,
    input  logic          head_valid,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_blue,
    output logic [7:0]    out_green,
    output logic [7:0]    out_red,
    output logic [7:0]    out_alpha,
    output logic          covered
);

    localparam int CH = grf_pkg::CH;
    localparam int QW = grf_pkg::QW;
    localparam int DW = grf_pkg::DW;

    logic advance;
    logic [DW-1:0] div_d;

    // divide stages: index 0 holds the product, index QW the quotient
    logic [QW:0]                dv_valid_reg;
    grf_pkg::px_t               dv_px_reg  [QW+1];
    logic [CH-1:0]              dv_neg_reg [QW+1];
    logic [CH-1:0][DW-1:0]      dv_rem_reg [QW+1];
    logic [CH-1:0][QW-1:0]      dv_qn_reg  [QW+1];
    logic [CH-1:0][DW-1:0]      dv_rem_next [QW+1];
    logic [CH-1:0][QW-1:0]      dv_qn_next  [QW+1];
    logic [CH-1:0][DW:0]        dv_acc [QW+1];
    logic [CH-1:0]              dv_ge  [QW+1];

    logic                       col_valid_reg;
    grf_pkg::px_t               col_px_reg;
    logic [CH-1:0][7:0]         col_src_reg;
    logic [CH-1:0][7:0]         col_src_next;
    logic [CH-1:0][7:0]         grad_col;

    logic                       mul_valid_reg;
    grf_pkg::px_t               mul_px_reg;
    logic [CH-1:0][15:0]        mul_sum_reg;
    logic [CH-1:0][15:0]        mul_sum_next;

    logic                       out_valid_reg;
    logic [CH-1:0][7:0]         out_ch_reg;
    logic [CH-1:0][7:0]         out_ch_next;
    logic [7:0]                 out_alpha_reg;
    logic                       covered_reg;
    logic [CH-1:0][16:0]        div255;

    // whole pipeline moves together; it halts only while the result waits
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && head_valid;
    assign div_d   = cfg.rect_height - 1'b1;

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            dv_rem_next[0][c] = '0;
            dv_qn_next[0][c]  = QW'(head.diff_mag[c]) * QW'(head.row_ofs);
            dv_acc[0][c]      = '0;
            dv_ge[0][c]       = 1'b0;
        end
        // one quotient bit per stage
        for (int k = 1; k <= QW; k++)
        begin
            for (int c = 0; c < CH; c++)
            begin
                dv_acc[k][c] = {dv_rem_reg[k-1][c], dv_qn_reg[k-1][c][QW-1]};
                dv_ge[k][c]  = dv_acc[k][c] >= {1'b0, div_d};
                dv_rem_next[k][c] = dv_ge[k][c] ? DW'(dv_acc[k][c] - {1'b0, div_d})
                                                : dv_acc[k][c][DW-1:0];
                dv_qn_next[k][c]  = {dv_qn_reg[k-1][c][QW-2:0], dv_ge[k][c]};
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            // apply the sign after dividing the magnitude: truncation toward zero
            grad_col[c] = dv_neg_reg[QW][c]
                        ? dv_px_reg[QW].c1[c] - dv_qn_reg[QW][c][7:0]
                        : dv_px_reg[QW].c1[c] + dv_qn_reg[QW][c][7:0];
            col_src_next[c] = dv_px_reg[QW].grad ? grad_col[c] : dv_px_reg[QW].c1[c];

            mul_sum_next[c] = 16'(col_src_reg[c]) * 16'(cfg.blend_alpha)
                            + 16'(col_px_reg.bg[c]) * 16'(8'd255 - cfg.blend_alpha);

            // floor(x / 255) for x below 255 * 256
            div255[c] = 17'(mul_sum_reg[c]) + 17'(mul_sum_reg[c] >> 8) + 17'd1;
            out_ch_next[c] = mul_px_reg.paint ? div255[c][15:8] : mul_px_reg.bg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg  <= '0;
            col_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            dv_valid_reg  <= {dv_valid_reg[QW-1:0], head_valid};
            col_valid_reg <= dv_valid_reg[QW];
            mul_valid_reg <= col_valid_reg;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_px_reg[0]  <= head.px;
            dv_neg_reg[0] <= head.diff_neg;
            for (int k = 0; k <= QW; k++)
            begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_qn_reg[k]  <= dv_qn_next[k];
            end
            for (int k = 1; k <= QW; k++)
            begin
                dv_px_reg[k]  <= dv_px_reg[k-1];
                dv_neg_reg[k] <= dv_neg_reg[k-1];
            end
            col_px_reg    <= dv_px_reg[QW];
            col_src_reg   <= col_src_next;
            mul_px_reg    <= col_px_reg;
            mul_sum_reg   <= mul_sum_next;
            out_ch_reg    <= out_ch_next;
            out_alpha_reg <= mul_px_reg.paint ? grf_pkg::ALPHA_OPAQUE : mul_px_reg.bg_a;
            covered_reg   <= mul_px_reg.covered;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blue  = out_ch_reg[grf_pkg::CH_BLUE];
    assign out_green = out_ch_reg[grf_pkg::CH_GREEN];
    assign out_red   = out_ch_reg[grf_pkg::CH_RED];
    assign out_alpha = out_alpha_reg;
    assign covered   = covered_reg;

endmodule

FILE: hw/rtl/gradient_rect_alpha_fill_core.sv
// Top level of the gradient rectangle alpha-fill compositor.
// Depends on grf_pkg, grf_front, grf_fifo and grf_back.
//
// Streams screen pixels, one transaction per clock while the front queue has
// room, and alpha-blends a solid or vertically graded fill color onto each
// pixel that lies in the configured rectangle after clipping to SCREEN_WIDTH x
// SCREEN_HEIGHT; other pixels pass unchanged. Sustained rate is one pixel per
// clock while the output is not stalled, with no state between pixels. A
// pixel goes through the four-entry front queue into the gradient product
// register, then through the divide by (height - 1), which retires one
// quotient bit per stage, then through the color, blend-multiply and output
// register stages.
// A waiting result stalls the back pipeline; the front queue keeps taking
// pixels until its four entries are full. Configuration registers are
// written through cfg_write/cfg_index/cfg_data and should only change while
// no pixel is in flight.
module gradient_rect_alpha_fill_core #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_write,
    input  logic [grf_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [grf_pkg::CFG_DW-1:0]  cfg_data,
    // pixel input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [9:0]                  pixel_col,
    input  logic [9:0]                  pixel_row,
    input  logic [7:0]                  bg_blue,
    input  logic [7:0]                  bg_green,
    input  logic [7:0]                  bg_red,
    input  logic [7:0]                  bg_alpha,
    // pixel result
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_blue,
    output logic [7:0]                  out_green,
    output logic [7:0]                  out_red,
    output logic [7:0]                  out_alpha,
    output logic                        covered
);

    grf_pkg::cfg_t cfg_reg;
    grf_pkg::fe_t  q_wdata;
    grf_pkg::fe_t  q_rdata;
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;

    // Configuration registers; blend alpha comes up opaque.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rect_left   <= '0;
            cfg_reg.rect_top    <= '0;
            cfg_reg.rect_width  <= '0;
            cfg_reg.rect_height <= '0;
            cfg_reg.color_start <= '0;
            cfg_reg.color_end   <= '0;
            cfg_reg.blend_alpha <= grf_pkg::ALPHA_OPAQUE;
            cfg_reg.gradient_on <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                grf_pkg::REG_RECT_LEFT:   cfg_reg.rect_left   <= cfg_data[11:0];
                grf_pkg::REG_RECT_TOP:    cfg_reg.rect_top    <= cfg_data[11:0];
                grf_pkg::REG_RECT_WIDTH:  cfg_reg.rect_width  <= cfg_data[10:0];
                grf_pkg::REG_RECT_HEIGHT: cfg_reg.rect_height <= cfg_data[10:0];
                grf_pkg::REG_COLOR_START: cfg_reg.color_start <= cfg_data[23:0];
                grf_pkg::REG_COLOR_END:   cfg_reg.color_end   <= cfg_data[23:0];
                grf_pkg::REG_BLEND_ALPHA: cfg_reg.blend_alpha <= cfg_data[7:0];
                grf_pkg::REG_GRADIENT_ON: cfg_reg.gradient_on <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Classify each pixel on accept: coverage, paint decision, gradient operands.
    grf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .bg_blue   (bg_blue),
        .bg_green  (bg_green),
        .bg_red    (bg_red),
        .bg_alpha  (bg_alpha),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_wdata)
    );

    // Decouple input acceptance from output stalls.
    grf_fifo #(
        .WIDTH ($bits(grf_pkg::fe_t)),
        .DEPTH (grf_pkg::QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // Gradient divide, blend and output register.
    grf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (q_rdata),
        .head_valid (!q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_blue   (out_blue),
        .out_green  (out_green),
        .out_red    (out_red),
        .out_alpha  (out_alpha),
        .covered    (covered)
    );

endmodule

FILE: hw/rtl/grf_checker.sv
// Port-level checker for gradient_rect_alpha_fill_core, bound to the top.
// Depends on grf_pkg and gradient_rect_alpha_fill_core_macros.svh.
`include "gradient_rect_alpha_fill_core_macros.svh"

module grf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_blue,
    input logic [7:0] out_green,
    input logic [7:0] out_red,
    input logic [7:0] out_alpha,
    input logic       covered
);

    localparam int PW = $clog2(grf_pkg::PIPE_SLOTS + 1) + 1;

    logic [PW-1:0] pend_reg;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // track transactions accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    `GRF_ASSERT_IMPL(a_no_spurious_result, clk, rst_n, out_valid, pend_reg != '0, "result with no pending pixel")
    `GRF_ASSERT_IMPL(a_occupancy_bound, clk, rst_n, 1'b1, pend_reg <= PW'(grf_pkg::PIPE_SLOTS), "more pixels in flight than slots")
    `GRF_ASSERT_IMPL(a_ready_low_only_backed_up, clk, rst_n, !in_ready, pend_reg >= PW'(grf_pkg::QDEPTH), "input stalled with queue not full")
    `GRF_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_blue, out_green, out_red, out_alpha, covered}), "stalled result changed")

endmodule

bind gradient_rect_alpha_fill_core grf_checker u_grf_checker (.*);
